// File: src/ksm_pkg.sv
// shared types, codes and constants for the kth-of-two-sorted-merge block
package ksm_pkg;

	localparam int KIND_W  = 2;
	localparam int ELEM_W  = 20;
	localparam int RANK_W  = 12;

	localparam int DEF_LIST_DEPTH = 1024;
	localparam int DEF_VALUE_BITS = 20;

	localparam logic [KIND_W-1:0] KIND_APPEND_A = 2'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND_B = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SELECT   = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ELEM_W-1:0] value;
		logic [RANK_W-1:0] rank;
	} in_word_t;

	typedef struct packed {
		logic [ELEM_W-1:0] element;
		logic              error;
	} out_word_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic append_a;
		logic append_b;
		logic close;
		logic emit_err;
		logic walk_init;
		logic walk_step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sel_bad;
		logic last_step;
	} status_t;

endpackage

// File: src/ksm_ctrl.sv
// controller state machine: decodes words and sequences the merge walk
module ksm_ctrl
	import ksm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [KIND_W-1:0]   kind,
	input  status_t             status,
	output cmd_t                cmd,
	output logic                busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (kind)
						KIND_APPEND_A: begin
							cmd.append_a = 1'b1;
						end
						KIND_APPEND_B: begin
							cmd.append_b = 1'b1;
						end
						KIND_SELECT: begin
							cmd.close = 1'b1;
							if (status.sel_bad) begin
								cmd.emit_err = 1'b1;
							end else begin
								cmd.walk_init = 1'b1;
								state_d       = ST_WALK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				busy          = 1'b1;
				cmd.walk_step = 1'b1;
				if (status.last_step) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: src/ksm_dpath.sv
// datapath: list stores, counts, merge pointers and result register
module ksm_dpath
	import ksm_pkg::*;
#(
	parameter int LIST_DEPTH = DEF_LIST_DEPTH,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic [ELEM_W-1:0]   value,
	input  logic [RANK_W-1:0]   rank,
	output status_t             status,
	output out_word_t           result,
	output logic                done
);

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int TOT_W = CNT_W + 1;
	localparam int CMP_W = (TOT_W > RANK_W) ? TOT_W : RANK_W;
	localparam int WIDE  = (VALUE_BITS > ELEM_W) ? VALUE_BITS : ELEM_W;

	logic [VALUE_BITS-1:0] mem_a [LIST_DEPTH];
	logic [VALUE_BITS-1:0] mem_b [LIST_DEPTH];

	logic [CNT_W-1:0]      cnt_a_q, cnt_b_q;
	logic                  closed_q;
	logic [CNT_W-1:0]      ptr_a_q, ptr_b_q;
	logic [RANK_W-1:0]     rem_q;
	logic [VALUE_BITS-1:0] head_a_q, head_b_q;
	logic [ELEM_W-1:0]     elem_q;
	logic                  err_q;
	logic                  done_q;

	logic [VALUE_BITS-1:0] wr_val;
	logic [IDX_W-1:0]      wr_idx_a, wr_idx_b;
	logic                  we_a, we_b;
	logic [CNT_W-1:0]      ptr_a_d, ptr_b_d;
	logic [IDX_W-1:0]      rd_idx_a, rd_idx_b;
	logic                  have_a, have_b, take_a;
	logic [VALUE_BITS-1:0] pick;
	logic [TOT_W-1:0]      total;

	// value masked or extended to the stored width
	assign wr_val = VALUE_BITS'(WIDE'(value));

	// an append after a select restarts both lists at entry zero
	assign we_a     = cmd.append_a && (closed_q || (cnt_a_q < CNT_W'(LIST_DEPTH)));
	assign we_b     = cmd.append_b && (closed_q || (cnt_b_q < CNT_W'(LIST_DEPTH)));
	assign wr_idx_a = closed_q ? '0 : cnt_a_q[IDX_W-1:0];
	assign wr_idx_b = closed_q ? '0 : cnt_b_q[IDX_W-1:0];

	// error check on the incoming rank
	assign total          = TOT_W'(cnt_a_q) + TOT_W'(cnt_b_q);
	assign status.sel_bad = (rank == '0) || (CMP_W'(rank) > CMP_W'(total));
	assign status.last_step = (rem_q == RANK_W'(1));

	// one merge step, A wins ties
	assign have_a = ptr_a_q < cnt_a_q;
	assign have_b = ptr_b_q < cnt_b_q;
	assign take_a = have_a && (!have_b || (head_a_q <= head_b_q));
	assign pick   = take_a ? head_a_q : head_b_q;

	always_comb begin
		ptr_a_d = ptr_a_q;
		ptr_b_d = ptr_b_q;
		if (cmd.walk_init) begin
			ptr_a_d = '0;
			ptr_b_d = '0;
		end else if (cmd.walk_step) begin
			if (take_a) begin
				ptr_a_d = ptr_a_q + CNT_W'(1);
			end else begin
				ptr_b_d = ptr_b_q + CNT_W'(1);
			end
		end
	end

	// prefetch the heads at the pointers of the next cycle
	assign rd_idx_a = ptr_a_d[IDX_W-1:0];
	assign rd_idx_b = ptr_b_d[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[wr_idx_a] <= wr_val;
		end
		head_a_q <= mem_a[rd_idx_a];
	end

	always_ff @(posedge clk) begin
		if (we_b) begin
			mem_b[wr_idx_b] <= wr_val;
		end
		head_b_q <= mem_b[rd_idx_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q  <= '0;
			cnt_b_q  <= '0;
			closed_q <= 1'b0;
		end else begin
			if (cmd.append_a || cmd.append_b) begin
				closed_q <= 1'b0;
				if (closed_q) begin
					cnt_a_q <= cmd.append_a ? CNT_W'(1) : '0;
					cnt_b_q <= cmd.append_b ? CNT_W'(1) : '0;
				end else begin
					if (we_a) begin
						cnt_a_q <= cnt_a_q + CNT_W'(1);
					end
					if (we_b) begin
						cnt_b_q <= cnt_b_q + CNT_W'(1);
					end
				end
			end else if (cmd.close) begin
				closed_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_a_q <= '0;
			ptr_b_q <= '0;
			rem_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			ptr_a_q <= ptr_a_d;
			ptr_b_q <= ptr_b_d;
			done_q  <= cmd.emit_err || (cmd.walk_step && status.last_step);
			if (cmd.walk_init) begin
				rem_q <= rank;
			end else if (cmd.walk_step) begin
				rem_q <= rem_q - RANK_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			elem_q <= '0;
			err_q  <= 1'b1;
		end else if (cmd.walk_step && status.last_step) begin
			elem_q <= ELEM_W'(WIDE'(pick));
			err_q  <= 1'b0;
		end
	end

	assign result.element = elem_q;
	assign result.error   = err_q;
	assign done           = done_q;

endmodule

// File: src/kth_of_two_sorted_merge.sv
// top level: rank selection over the merge of two sorted lists
//
// words come in on item when start is high and busy is low. an append word
// (kind 0 to list a, kind 1 to list b) leaves busy low, so appends can
// stream in every cycle; an append to a full list is dropped, and the first
// append after a select begins a fresh pair of lists. kind 3 is ignored. a
// select word (kind 2) with rank k walks a two-pointer merge, one merged
// element per cycle, taking list a on ties: busy is high during the walk and
// the answer shows on result with done high for exactly one cycle right
// after the walk. the walk rate is set by the single registered read port of
// each list store, which is addressed with the next pointer so the heads are
// prefetched. a rank of zero or above the total element count gives error
// with element zero in the cycle after the select, with no busy time. the
// receiver cannot stall results: done marks a word that must be taken in
// that cycle. a new word may be accepted in the same cycle a result is shown.
module kth_of_two_sorted_merge
	import ksm_pkg::*;
#(
	parameter int LIST_DEPTH = DEF_LIST_DEPTH,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_word_t  item,
	output logic      done,
	output out_word_t result
);

	// command and status between controller and datapath
	cmd_t    cmd;
	status_t status;

	// word decode and walk sequencing
	ksm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (item.kind),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// list stores, counts, merge pointers, result register
	ksm_dpath #(
		.LIST_DEPTH (LIST_DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.value  (item.value),
		.rank   (item.rank),
		.status (status),
		.result (result),
		.done   (done)
	);

endmodule
